// ===== rtl/core/ptt_pkg.sv =====
package ptt_pkg;

    // table geometry
    localparam int PTT_SLOTS = 8;
    // most results one dispatch transaction may produce
    localparam int MAX_OUT   = 8;

    localparam int ID_W    = 8;
    localparam int TICK_W  = 16;
    localparam int ACT_W   = 2;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    // command codes carried on s_tuser
    typedef enum logic [ACT_W-1:0] {
        ACT_ADD      = 2'd0,
        ACT_DELETE   = 2'd1,
        ACT_TICK     = 2'd2,
        ACT_DISPATCH = 2'd3
    } action_t;

    // one slot of the table
    typedef struct packed {
        logic [ID_W-1:0]   tid;
        logic [TICK_W-1:0] delay;
        logic [TICK_W-1:0] period;
        logic              ready;
    } slot_rec_t;

    // command held for the whole pass round the ring
    typedef struct packed {
        action_t           action;
        logic [ID_W-1:0]   tid;
        logic [TICK_W-1:0] delay;
        logic [TICK_W-1:0] period;
    } cmd_t;

    // progress of the current pass, seen by the head unit
    typedef struct packed {
        logic present;
        logic placed;
        logic deleted;
        logic limit;
    } pass_flags_t;

    // what the head unit did to the slot it just saw
    typedef struct packed {
        logic serve;
        logic placed_now;
        logic deleted_now;
    } head_effect_t;

endpackage

// ===== rtl/core/ptt_cell.sv =====
module ptt_cell
    import ptt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      shift_en,
    input  slot_rec_t rec_in,
    output slot_rec_t rec_out
);

    slot_rec_t rec_reg;

    // slot storage, takes its neighbour's record on every ring step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg <= '0;
        end else if (shift_en) begin
            rec_reg <= rec_in;
        end
    end

    assign rec_out = rec_reg;

endmodule

// ===== rtl/core/ptt_head.sv =====
module ptt_head
    import ptt_pkg::*;
(
    input  slot_rec_t    rec_i,
    input  cmd_t         cmd,
    input  pass_flags_t  flags,
    output slot_rec_t    rec_o,
    output head_effect_t effect
);

    logic occ;
    logic hit;

    assign occ = (rec_i.tid != '0);
    assign hit = (cmd.tid != '0) && (rec_i.tid == cmd.tid);

    // update of the slot passing the head of the ring
    always_comb begin
        rec_o  = rec_i;
        effect = '0;
        case (cmd.action)
            ACT_ADD: begin
                if (cmd.tid != '0) begin
                    if (flags.present) begin
                        if (hit) begin
                            rec_o.delay = cmd.delay;
                        end
                    end else if (!flags.placed && !occ) begin
                        rec_o.tid         = cmd.tid;
                        rec_o.delay       = cmd.delay;
                        rec_o.period      = cmd.period;
                        rec_o.ready       = 1'b0;
                        effect.placed_now = 1'b1;
                    end
                end
            end
            ACT_DELETE: begin
                if (hit && !flags.deleted) begin
                    rec_o              = '0;
                    effect.deleted_now = 1'b1;
                end
            end
            ACT_TICK: begin
                if (occ) begin
                    if (rec_i.delay == '0) begin
                        rec_o.ready = 1'b1;
                        rec_o.delay = rec_i.period;
                    end else begin
                        rec_o.delay = TICK_W'(rec_i.delay - 1'b1);
                    end
                end
            end
            ACT_DISPATCH: begin
                if (occ && rec_i.ready && !flags.limit) begin
                    effect.serve = 1'b1;
                    rec_o.ready  = 1'b0;
                    // one-shot task leaves the table
                    if (rec_i.period == '0) begin
                        rec_o.tid   = '0;
                        rec_o.delay = '0;
                    end
                end
            end
            default: begin
                rec_o = rec_i;
            end
        endcase
    end

endmodule

// ===== rtl/core/periodic_task_timer_table_top.sv =====
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tuser action, s_tdata task_id, delay, period
// m_       out  m_tvalid/m_tready  m_tdata out_task, ok; m_tlast last
//
// every transaction makes one full turn of the slot ring (slot k passes the
// head unit at step k of the turn) after it is accepted in the idle state; a new
// item is taken only once the turn is over and the block is idle again.
// reset clears every slot at once; the block takes an item on the first
// cycle after reset. a full output register holds the ring while a result
// must be written, so a stall costs cycles only while a result is waiting.
module periodic_task_timer_table_top
    import ptt_pkg::*;
#(
    parameter int SLOTS = PTT_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // task_id [7:0], delay_ticks [23:8], period_ticks [39:24]
    input  logic [1:0]  s_tuser,   // action [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_task [7:0], ok [8], zero fill [15:9]
    output logic        m_tlast
);

    localparam int STEP_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t            state_reg,   state_next;
    cmd_t              cmd_reg,     cmd_next;
    logic              present_reg, present_next;
    logic              placed_reg,  placed_next;
    logic              deleted_reg, deleted_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;
    logic [STEP_W-1:0] step_reg,    step_next;
    logic              m_valid_reg, m_valid_next;
    logic [ID_W-1:0]   m_task_reg,  m_task_next;
    logic              m_ok_reg,    m_ok_next;
    logic              m_last_reg,  m_last_next;

    slot_rec_t         ring   [SLOTS];
    slot_rec_t         head_rec;
    head_effect_t      effect;
    pass_flags_t       flags;
    logic [SLOTS-1:0]  hit_vec;
    logic [SLOTS-1:0]  pend_vec;
    logic              rest_ready;
    logic              advance;
    logic              final_step;
    logic              need_out;
    logic              out_free;
    logic              add_ok;
    logic              s_accept;

    // ring of slot cells, the head record goes back in at the tail
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        slot_rec_t rec_in;
        if (i == SLOTS - 1) begin : g_tail
            assign rec_in = head_rec;
        end else begin : g_mid
            assign rec_in = ring[i+1];
        end
        ptt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (advance),
            .rec_in   (rec_in),
            .rec_out  (ring[i])
        );
    end

    // per-slot id match and still-ready flags
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            hit_vec[i]  = (ring[i].tid == s_tdata[7:0]);
            pend_vec[i] = (ring[i].tid != '0) && ring[i].ready;
        end
    end

    // slots behind the head: served ones are already cleared
    assign rest_ready = |(pend_vec >> 1);

    assign flags.present = present_reg;
    assign flags.placed  = placed_reg;
    assign flags.deleted = deleted_reg;
    assign flags.limit   = (cnt_reg == CNT_W'(MAX_OUT));

    ptt_head u_head (
        .rec_i  (ring[0]),
        .cmd    (cmd_reg),
        .flags  (flags),
        .rec_o  (head_rec),
        .effect (effect)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign final_step = (step_reg == STEP_W'(SLOTS - 1));
    assign out_free   = !m_valid_reg || m_tready;
    assign add_ok     = (cmd_reg.tid != '0) && (present_reg || placed_reg || effect.placed_now);

    // a result is written on a serve, or at the end of the turn (for a dispatch only if nothing was served)
    always_comb begin
        if (cmd_reg.action == ACT_DISPATCH) begin
            need_out = effect.serve || (final_step && (cnt_reg == '0));
        end else begin
            need_out = final_step;
        end
    end

    assign advance = (state_reg == ST_RUN) && (!need_out || out_free);

    // control and result register next values
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        present_next = present_reg;
        placed_next  = placed_reg;
        deleted_next = deleted_reg;
        cnt_next     = cnt_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        m_task_next  = m_task_reg;
        m_ok_next    = m_ok_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd_next.action = action_t'(s_tuser);
                    cmd_next.tid    = s_tdata[7:0];
                    cmd_next.delay  = s_tdata[23:8];
                    cmd_next.period = s_tdata[39:24];
                    present_next    = |hit_vec;
                    placed_next     = 1'b0;
                    deleted_next    = 1'b0;
                    cnt_next        = '0;
                    step_next       = '0;
                    state_next      = ST_RUN;
                end
            end
            ST_RUN: begin
                if (advance) begin
                    placed_next  = placed_reg | effect.placed_now;
                    deleted_next = deleted_reg | effect.deleted_now;
                    step_next    = final_step ? '0 : STEP_W'(step_reg + 1'b1);
                    if (effect.serve) begin
                        cnt_next = CNT_W'(cnt_reg + 1'b1);
                    end
                    if (final_step) begin
                        state_next = ST_IDLE;
                    end
                    if (need_out) begin
                        m_valid_next = 1'b1;
                        m_last_next  = 1'b1;
                        case (cmd_reg.action)
                            ACT_ADD: begin
                                m_task_next = cmd_reg.tid;
                                m_ok_next   = add_ok;
                            end
                            ACT_DELETE: begin
                                m_task_next = cmd_reg.tid;
                                m_ok_next   = deleted_reg | effect.deleted_now;
                            end
                            ACT_TICK: begin
                                m_task_next = '0;
                                m_ok_next   = 1'b1;
                            end
                            ACT_DISPATCH: begin
                                if (effect.serve) begin
                                    m_task_next = ring[0].tid;
                                    m_ok_next   = 1'b1;
                                    m_last_next = !rest_ready
                                                  || (cnt_reg == CNT_W'(MAX_OUT - 1));
                                end else begin
                                    m_task_next = '0;
                                    m_ok_next   = 1'b0;
                                end
                            end
                            default: begin
                                m_task_next = '0;
                                m_ok_next   = 1'b0;
                            end
                        endcase
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, pass control and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            placed_reg  <= 1'b0;
            deleted_reg <= 1'b0;
            present_reg <= 1'b0;
            cnt_reg     <= '0;
            step_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            placed_reg  <= placed_next;
            deleted_reg <= deleted_next;
            present_reg <= present_next;
            cnt_reg     <= cnt_next;
            step_reg    <= step_next;
        end
        cmd_reg    <= cmd_next;
        m_task_reg <= m_task_next;
        m_ok_reg   <= m_ok_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_ok_reg, m_task_reg};
    assign m_tlast  = m_last_reg;

endmodule
